>>> design/ftprp_pkg.sv
// Shared types and constants for the FTP reply line parser.
`default_nettype none

package ftprp_pkg;

  // Results one received byte can cause, at most
  localparam int MaxResults = 8;
  localparam int SlotIdxW   = $clog2(MaxResults);
  localparam int SlotCntW   = $clog2(MaxResults + 1);

  // Default depth of the command queue between front and back
  localparam int QueueDepthDefault = 4;

  // Field widths
  localparam int ByteW = 8;
  localparam int CodeW = 10;
  localparam int LenW  = 2;
  localparam int IdxW  = 2;

  // Configuration register indexes
  localparam logic [IdxW-1:0] RegDelimFirst  = 2'd0;
  localparam logic [IdxW-1:0] RegDelimSecond = 2'd1;
  localparam logic [IdxW-1:0] RegDelimLength = 2'd2;

  // Configuration reset values
  localparam logic [ByteW-1:0] DelimFirstReset  = 8'd13;
  localparam logic [ByteW-1:0] DelimSecondReset = 8'd10;
  localparam logic [LenW-1:0]  DelimLengthReset = 2'd2;
  localparam logic [LenW-1:0]  DelimLengthOne   = 2'd1;

  // Characters
  localparam logic [ByteW-1:0] CharCr    = 8'h0d;
  localparam logic [ByteW-1:0] CharLf    = 8'h0a;
  localparam logic [ByteW-1:0] CharDash  = 8'h2d;
  localparam logic [ByteW-1:0] CharSpace = 8'h20;
  localparam logic [ByteW-1:0] CharZero  = 8'h30;
  localparam logic [ByteW-1:0] CharNine  = 8'h39;

  // One result of a command: a body byte or a done marker
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             done;
  } slot_t;

  // Everything one received byte produces, as queued for the back end
  typedef struct packed {
    logic [CodeW-1:0]              tag;
    logic [SlotIdxW-1:0]           last;
    slot_t [MaxResults-1:0]        slots;
  } cmd_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

endpackage

`default_nettype wire

>>> design/ftprp_front.sv
// Front end: configuration registers, line splitting and classification into commands.
`default_nettype none

module ftprp_front
  import ftprp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic [IdxW-1:0]   wr_index,
  input  wire logic [ByteW-1:0]  wr_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [ByteW-1:0]  in_byte,
  input  wire q_status_t         q_status,
  output logic                   push,
  output cmd_t                   push_cmd
);

  // Line state plus the result list built while one byte is worked through
  typedef struct packed {
    logic [2:0]             len;
    logic [3:0][ByteW-1:0]  head;
    logic [CodeW-1:0]       code;
    logic                   numeric;
    logic                   in_multi;
    logic [CodeW-1:0]       multi_code;
    logic [SlotCntW-1:0]    cnt;
    logic [CodeW-1:0]       tag;
    slot_t [MaxResults-1:0] slots;
  } work_t;

  logic [ByteW-1:0]      delim_first;
  logic [ByteW-1:0]      delim_second;
  logic [LenW-1:0]       delim_length;
  logic                  delim_pending;
  logic                  delim_pending_next;
  logic [2:0]            line_length;
  logic [3:0][ByteW-1:0] line_head;
  logic [CodeW-1:0]      line_code;
  logic                  line_numeric;
  logic                  in_multi;
  logic [CodeW-1:0]      multi_code;
  work_t                 w;
  logic                  accept;

  function automatic work_t put_slot(work_t wi, logic [CodeW-1:0] tag,
                                     logic [ByteW-1:0] d, logic done);
    work_t r;
    r = wi;
    if (r.cnt < SlotCntW'(MaxResults)) begin
      r.slots[r.cnt[SlotIdxW-1:0]] = '{data: d, done: done};
      r.cnt = r.cnt + SlotCntW'(1);
    end
    r.tag = tag;
    return r;
  endfunction

  function automatic work_t put_head(work_t wi, logic [CodeW-1:0] tag, logic [2:0] n);
    work_t r;
    r = wi;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < n) r = put_slot(r, tag, wi.head[i], 1'b0);
    end
    return r;
  endfunction

  function automatic work_t put_crlf(work_t wi, logic [CodeW-1:0] tag);
    work_t r;
    r = put_slot(wi, tag, CharCr, 1'b0);
    r = put_slot(r, tag, CharLf, 1'b0);
    return r;
  endfunction

  function automatic work_t add_char(work_t wi, logic [ByteW-1:0] c);
    work_t            r;
    logic [CodeW-1:0] tag;
    logic             emit;
    r = wi;
    if (r.len < 3'd4) begin
      // Hold the head byte and fold digits into the code
      r.head[r.len[1:0]] = c;
      if (r.len < 3'd3) begin
        if (c >= CharZero && c <= CharNine)
          r.code = CodeW'(r.code * CodeW'(10) + CodeW'(c - CharZero));
        else
          r.numeric = 1'b0;
      end
      r.len = r.len + 3'd1;
    end else begin
      tag  = r.in_multi ? r.multi_code : r.code;
      emit = r.numeric || r.in_multi;
      if (r.len == 3'd4) begin
        if (!r.numeric && r.in_multi) r = put_head(r, tag, 3'd4);
        r.len = 3'd5;
      end
      if (emit) r = put_slot(r, tag, c, 1'b0);
    end
    return r;
  endfunction

  function automatic work_t end_line(work_t wi);
    work_t            r;
    logic [ByteW-1:0] sep;
    r = wi;
    if (r.len >= 3'd3) begin
      sep = (r.len > 3'd3) ? r.head[3] : CharSpace;
      if (!r.numeric) begin
        // Text line inside a multi-line reply passes whole
        if (r.in_multi) begin
          if (r.len <= 3'd4) r = put_head(r, r.multi_code, r.len);
          r = put_crlf(r, r.multi_code);
        end
      end else if (r.in_multi) begin
        if (r.code == r.multi_code && sep == CharSpace) begin
          r = put_slot(r, r.multi_code, '0, 1'b1);
          r.in_multi = 1'b0;
        end else begin
          if (r.len <= 3'd4) r = put_head(r, r.multi_code, r.len);
          r = put_crlf(r, r.multi_code);
        end
      end else if (sep == CharDash && r.code != '0) begin
        // Open a multi-line reply
        r.in_multi   = 1'b1;
        r.multi_code = r.code;
        if (r.len >= 3'd5) r = put_crlf(r, r.code);
      end else begin
        r = put_slot(r, r.code, '0, 1'b1);
      end
    end
    r.len     = 3'd0;
    r.code    = '0;
    r.numeric = 1'b1;
    return r;
  endfunction

  // Stall while the queue has no room
  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  // Work one byte through the delimiter and line rules
  always_comb begin
    w.len        = line_length;
    w.head       = line_head;
    w.code       = line_code;
    w.numeric    = line_numeric;
    w.in_multi   = in_multi;
    w.multi_code = multi_code;
    w.cnt        = '0;
    w.tag        = '0;
    w.slots      = '0;
    delim_pending_next = delim_pending;
    if (delim_pending) begin
      if (in_byte == delim_second) begin
        delim_pending_next = 1'b0;
        w = end_line(w);
      end else begin
        w = add_char(w, delim_first);
        if (in_byte == delim_first && delim_length != DelimLengthOne) begin
          delim_pending_next = 1'b1;
        end else if (in_byte == delim_first) begin
          delim_pending_next = 1'b0;
          w = end_line(w);
        end else begin
          delim_pending_next = 1'b0;
          w = add_char(w, in_byte);
        end
      end
    end else if (in_byte == delim_first) begin
      if (delim_length == DelimLengthOne) w = end_line(w);
      else delim_pending_next = 1'b1;
    end else begin
      w = add_char(w, in_byte);
    end
  end

  // Queue only bytes that cause results
  assign push           = accept && (w.cnt != '0);
  assign push_cmd.tag   = w.tag;
  assign push_cmd.last  = SlotIdxW'(w.cnt - SlotCntW'(1));
  assign push_cmd.slots = w.slots;

  // Configuration and line control state
  always_ff @(posedge clk) begin
    if (rst) begin
      delim_first   <= DelimFirstReset;
      delim_second  <= DelimSecondReset;
      delim_length  <= DelimLengthReset;
      delim_pending <= 1'b0;
      line_length   <= 3'd0;
      line_code     <= '0;
      line_numeric  <= 1'b1;
      in_multi      <= 1'b0;
      multi_code    <= '0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          RegDelimFirst:  delim_first  <= wr_data;
          RegDelimSecond: delim_second <= wr_data;
          RegDelimLength: delim_length <= wr_data[LenW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        delim_pending <= delim_pending_next;
        line_length   <= w.len;
        line_code     <= w.code;
        line_numeric  <= w.numeric;
        in_multi      <= w.in_multi;
        multi_code    <= w.multi_code;
      end
    end
  end

  // Hold the first bytes of the line
  always_ff @(posedge clk) begin
    if (accept) line_head <= w.head;
  end

endmodule

`default_nettype wire

>>> design/ftprp_queue.sv
// Command queue between front and back ends.
`default_nettype none

module ftprp_queue
  import ftprp_pkg::*;
#(
  parameter int Depth = QueueDepthDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output q_status_t status
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign status.full      = (count == CntW'(Depth));
  assign status.not_empty = (count != '0);
  assign do_push          = push && !status.full;
  assign do_pop           = pop && status.not_empty;
  assign head             = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      if (do_push && !do_pop)      count <= count + CntW'(1);
      else if (do_pop && !do_push) count <= count - CntW'(1);
    end
  end

  // Store the command
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_cmd;
  end

endmodule

`default_nettype wire

>>> design/ftprp_back.sv
// Back end: expands queued commands into result transfers, one per cycle unless stalled.
`default_nettype none

module ftprp_back
  import ftprp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              head,
  input  wire q_status_t         q_status,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CodeW-1:0]       reply_code,
  output logic [ByteW-1:0]       body_byte,
  output logic                   byte_valid,
  output logic                   reply_done,
  output logic                   run_last
);

  logic [SlotIdxW-1:0] slot_idx;
  logic                load;
  logic                take;
  logic                at_last;
  slot_t               cur;

  assign load    = !out_valid || !out_stall;
  assign take    = load && q_status.not_empty;
  assign cur     = head.slots[slot_idx];
  assign at_last = (slot_idx == head.last);
  assign pop     = take && at_last;

  // Step through the slots and drop the command after its last one
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      slot_idx  <= '0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        slot_idx  <= at_last ? '0 : slot_idx + SlotIdxW'(1);
      end else if (load) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (take) begin
      reply_code <= head.tag;
      body_byte  <= cur.data;
      byte_valid <= !cur.done;
      reply_done <= cur.done;
      run_last   <= at_last;
    end
  end

endmodule

`default_nettype wire

>>> design/ftp_reply_line_parser_top.sv
// Top level of the FTP reply line parser.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------------------
//  input    | in_valid / in_stall     | in_byte
//  output   | out_valid / out_stall   | reply_code, body_byte, byte_valid, reply_done,
//           |                         | run_last
//  config   | wr_en                   | wr_index, wr_data
//
// One byte is accepted per cycle whenever the command queue has room.
// A byte that causes n results (0 to 7) occupies the output for n transfers; the
// output register gives one result per cycle while out_stall is low, so sustained
// rate is set by results per byte. Each result passes the queue and the output register.
// Reset is synchronous and clears control state; no clearing pass is needed.
// Output stalls fill the queue, then in_stall rises.
`default_nettype none

module ftp_reply_line_parser_top
  import ftprp_pkg::*;
#(
  parameter int QueueDepth = QueueDepthDefault
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic [IdxW-1:0]   wr_index,
  input  wire logic [ByteW-1:0]  wr_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [ByteW-1:0]  in_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CodeW-1:0]       reply_code,
  output logic [ByteW-1:0]       body_byte,
  output logic                   byte_valid,
  output logic                   reply_done,
  output logic                   run_last
);

  q_status_t q_status;
  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      head;

  ftprp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  ftprp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  ftprp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .reply_code (reply_code),
    .body_byte  (body_byte),
    .byte_valid (byte_valid),
    .reply_done (reply_done),
    .run_last   (run_last)
  );

endmodule

`default_nettype wire

>>> design/ftprp_checker.sv
// Port-level checks for the FTP reply line parser, bound to the top level.
`default_nettype none

module ftprp_checker
  import ftprp_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [CodeW-1:0] reply_code,
  input wire logic [ByteW-1:0] body_byte,
  input wire logic             byte_valid,
  input wire logic             reply_done,
  input wire logic             run_last
);

  // A result is either a body byte or a done marker
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_valid != reply_done))
    else $error("result is neither exactly a byte nor a done marker");

  // A done marker carries a zero byte and closes its run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && reply_done |-> run_last && body_byte == '0)
    else $error("done marker not last of its run or byte not zero");

  // Results of one run share one code
  a_run_code: assert property (@(posedge clk) disable iff (rst)
    $past(out_valid && !out_stall && !run_last) && out_valid
      |-> reply_code == $past(reply_code))
    else $error("reply code changed inside a run");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(reply_code) && $stable(body_byte)
      && $stable(run_last))
    else $error("stalled result changed");

endmodule

bind ftp_reply_line_parser_top ftprp_checker u_ftprp_checker (.*);

`default_nettype wire

>>> tb/ftp_reply_line_parser_top_tb.sv
// Self-checking testbench for the FTP reply line parser top level.
module ftp_reply_line_parser_top_tb
  import ftprp_pkg::*;
;

  localparam int SettleCycles = 16;
  localparam int HoldCycles   = 200;
  localparam int PhaseBytes   = 30;
  localparam int NumPhases    = 6;

  // One output transfer of the parser
  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [ByteW-1:0] data;
    logic             valid;
    logic             done;
    logic             last;
  } reply_item_t;

  // Tracks parser state and holds the reply bytes still owed by the block
  class reply_scoreboard;
    logic [ByteW-1:0] delim_a;
    logic [ByteW-1:0] delim_b;
    logic [LenW-1:0]  delim_n;
    bit               held_first;
    int unsigned      line_len;
    logic [ByteW-1:0] head_q [4];
    logic [CodeW-1:0] line_cd;
    logic [CodeW-1:0] open_cd;
    bit               all_digits;
    bit               inside_multi;
    reply_item_t      step_out[$];
    reply_item_t      owed_q[$];
    int               errors;

    function new();
      delim_a      = DelimFirstReset;
      delim_b      = DelimSecondReset;
      delim_n      = DelimLengthReset;
      held_first   = 0;
      line_len     = 0;
      line_cd      = '0;
      open_cd      = '0;
      all_digits   = 1;
      inside_multi = 0;
      errors       = 0;
      foreach (head_q[i]) head_q[i] = '0;
    endfunction

    function void write_reg(logic [IdxW-1:0] idx, logic [ByteW-1:0] val);
      case (idx)
        RegDelimFirst:  delim_a = val;
        RegDelimSecond: delim_b = val;
        RegDelimLength: delim_n = val[LenW-1:0];
        default: ;
      endcase
    endfunction

    function void emit(logic [CodeW-1:0] code, logic [ByteW-1:0] data, logic valid,
                       logic done);
      reply_item_t r;
      r.code  = code;
      r.data  = data;
      r.valid = valid;
      r.done  = done;
      r.last  = 1'b0;
      if (step_out.size() < MaxResults) step_out.insert(step_out.size(), r);
    endfunction

    function void emit_crlf(logic [CodeW-1:0] code);
      emit(code, CharCr, 1'b1, 1'b0);
      emit(code, CharLf, 1'b1, 1'b0);
    endfunction

    function void emit_head(logic [CodeW-1:0] code, int unsigned n);
      for (int unsigned i = 0; i < n && i < 4; i++) emit(code, head_q[i], 1'b1, 1'b0);
    endfunction

    // Add one byte to the current line: hold the head, stream the rest
    function void take_char(logic [ByteW-1:0] c);
      logic [CodeW-1:0] tag;
      if (line_len < 4) begin
        head_q[line_len] = c;
        if (line_len < 3) begin
          if (c >= CharZero && c <= CharNine)
            line_cd = CodeW'(int'(line_cd) * 10 + int'(c - CharZero));
          else
            all_digits = 0;
        end
        line_len++;
      end else begin
        tag = inside_multi ? open_cd : line_cd;
        if (line_len == 4) begin
          if (!all_digits && inside_multi) emit_head(tag, 4);
          line_len = 5;
        end
        if (all_digits || inside_multi) emit(tag, c, 1'b1, 1'b0);
      end
    endfunction

    // Decide the role of a finished line
    function void close_line();
      int unsigned      n;
      logic [ByteW-1:0] sep;
      n = line_len;
      if (n >= 3) begin
        sep = (n > 3) ? head_q[3] : CharSpace;
        if (!all_digits) begin
          if (inside_multi) begin
            if (n <= 4) emit_head(open_cd, n);
            emit_crlf(open_cd);
          end
        end else if (inside_multi) begin
          if (line_cd == open_cd && sep == CharSpace) begin
            emit(open_cd, '0, 1'b0, 1'b1);
            inside_multi = 0;
          end else begin
            if (n <= 4) emit_head(open_cd, n);
            emit_crlf(open_cd);
          end
        end else if (sep == CharDash && line_cd != '0) begin
          inside_multi = 1;
          open_cd      = line_cd;
          if (n >= 5) emit_crlf(open_cd);
        end else begin
          emit(line_cd, '0, 1'b0, 1'b1);
        end
      end
      line_len   = 0;
      line_cd    = '0;
      all_digits = 1;
    endfunction

    // Note an accepted input byte and queue what it should produce
    function void note_byte(logic [ByteW-1:0] b);
      reply_item_t r;
      step_out.delete();
      if (held_first) begin
        if (b == delim_b) begin
          held_first = 0;
          close_line();
        end else begin
          take_char(delim_a);
          if (b == delim_a && delim_n != DelimLengthOne) begin
            held_first = 1;
          end else if (b == delim_a) begin
            held_first = 0;
            close_line();
          end else begin
            held_first = 0;
            take_char(b);
          end
        end
      end else if (b == delim_a) begin
        if (delim_n == DelimLengthOne) close_line();
        else held_first = 1;
      end else begin
        take_char(b);
      end
      if (step_out.size() > 0) begin
        r = step_out.pop_back();
        r.last = 1'b1;
        step_out.insert(step_out.size(), r);
      end
      foreach (step_out[i]) owed_q.insert(owed_q.size(), step_out[i]);
    endfunction

    // Compare one output transfer against the oldest owed result
    function void check_result(reply_item_t got);
      reply_item_t want;
      if (owed_q.size() == 0) begin
        $error("unexpected result: code %0d byte %0d valid %0b done %0b last %0b",
               got.code, got.data, got.valid, got.done, got.last);
        errors++;
      end else begin
        want = owed_q.pop_front();
        if (got.code !== want.code) begin
          $error("reply_code mismatch: expected %0d, got %0d", want.code, got.code);
          errors++;
        end
        if (got.data !== want.data) begin
          $error("body_byte mismatch: expected %0d, got %0d", want.data, got.data);
          errors++;
        end
        if (got.valid !== want.valid) begin
          $error("byte_valid mismatch: expected %0b, got %0b", want.valid, got.valid);
          errors++;
        end
        if (got.done !== want.done) begin
          $error("reply_done mismatch: expected %0b, got %0b", want.done, got.done);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("run_last mismatch: expected %0b, got %0b", want.last, got.last);
          errors++;
        end
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             wr_en;
  logic [IdxW-1:0]  wr_index;
  logic [ByteW-1:0] wr_data;
  logic             in_valid;
  logic             in_stall;
  logic [ByteW-1:0] in_byte;
  logic             out_valid;
  logic             out_stall;
  logic [CodeW-1:0] reply_code;
  logic [ByteW-1:0] body_byte;
  logic             byte_valid;
  logic             reply_done;
  logic             run_last;

  reply_scoreboard  sb;
  reply_item_t      seen;
  logic [ByteW-1:0] line_buf[$];
  int               burst_left;
  int               sent_count;
  bit               no_gaps;
  bit               hold_req;

  ftp_reply_line_parser_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .reply_code (reply_code),
    .body_byte  (body_byte),
    .byte_valid (byte_valid),
    .reply_done (reply_done),
    .run_last   (run_last)
  );

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Give up after a generous fixed time
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Check every output transfer
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen.code  = reply_code;
      seen.data  = body_byte;
      seen.valid = byte_valid;
      seen.done  = reply_done;
      seen.last  = run_last;
      sb.check_result(seen);
    end
  end

  // Receiver stall patterns, plus one long hold-off on request
  initial begin
    int  mode;
    int  mode_left;
    int  hold_left;
    int  tick;
    logic stall;
    out_stall = 1'b0;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_req && hold_left == 0) begin
        hold_left = HoldCycles;
        hold_req  = 0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 40);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else begin
        case (mode)
          0:       stall = 1'b0;
          1:       stall = ($urandom_range(0, 3) == 0);
          2:       stall = ($urandom_range(0, 1) == 0);
          default: stall = (tick % 3 == 0);
        endcase
      end
      out_stall <= stall;
    end
  end

  // Offer one byte and hold it until the transfer; open bursts with random gaps
  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_byte(b);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_delim();
    send_byte(sb.delim_a);
    if (sb.delim_n != DelimLengthOne) send_byte(sb.delim_b);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i]);
    send_delim();
    line_buf.delete();
  endtask

  // Stop offering and wait until every owed result has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Write all three delimiter registers on consecutive cycles
  task automatic set_config(input logic [ByteW-1:0] first, input logic [ByteW-1:0] second,
                            input logic [LenW-1:0] len);
    logic [IdxW-1:0]  idx [3];
    logic [ByteW-1:0] val [3];
    idx[0] = RegDelimFirst;  val[0] = first;
    idx[1] = RegDelimSecond; val[1] = second;
    idx[2] = RegDelimLength; val[2] = ByteW'(len);
    for (int i = 0; i < 3; i++) begin
      wr_en    <= 1'b1;
      wr_index <= idx[i];
      wr_data  <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
      @(negedge clk);
    end
    wr_en <= 1'b0;
  endtask

  function automatic logic [ByteW-1:0] body_char();
    logic [ByteW-1:0] r;
    do r = ByteW'($urandom_range(0, 255)); while (r == sb.delim_a);
    return r;
  endfunction

  function automatic void push_code(int c);
    line_buf.insert(line_buf.size(), CharZero + ByteW'(c / 100));
    line_buf.insert(line_buf.size(), CharZero + ByteW'((c / 10) % 10));
    line_buf.insert(line_buf.size(), CharZero + ByteW'(c % 10));
  endfunction

  // Body text; in two-byte mode sometimes a lone first delimiter byte
  function automatic void push_body(int n);
    for (int i = 0; i < n; i++) begin
      if (sb.delim_n != DelimLengthOne && $urandom_range(0, 9) == 0)
        line_buf.insert(line_buf.size(), sb.delim_a);
      else
        line_buf.insert(line_buf.size(), body_char());
    end
  endfunction

  // One random reply: mostly well-formed, some noise and broken replies
  task automatic send_reply();
    int kind;
    int code;
    int lines;
    int pick;
    kind = $urandom_range(0, 9);
    code = $urandom_range(0, 999);
    if (kind <= 3) begin
      push_code(code);
      pick = $urandom_range(0, 5);
      if (pick <= 2) begin
        line_buf.insert(line_buf.size(), CharSpace);
        push_body($urandom_range(0, 6));
      end else if (pick == 4) begin
        line_buf.insert(line_buf.size(), CharDash);
        push_body($urandom_range(0, 3));
      end else if (pick == 5) begin
        push_body($urandom_range(1, 6));
      end
      send_line();
    end else if (kind <= 7 || kind == 9) begin
      code = $urandom_range(1, 999);
      push_code(code);
      line_buf.insert(line_buf.size(), CharDash);
      push_body($urandom_range(0, 5));
      send_line();
      lines = $urandom_range(0, 3);
      for (int i = 0; i < lines; i++) begin
        pick = $urandom_range(0, 5);
        case (pick)
          0: begin
            push_code($urandom_range(0, 999));
            line_buf.insert(line_buf.size(), $urandom_range(0, 1) ? CharSpace : CharDash);
            push_body($urandom_range(0, 5));
          end
          1: begin
            push_code(code);
            line_buf.insert(line_buf.size(), CharDash);
            push_body($urandom_range(0, 5));
          end
          2: begin
            push_code(code);
            push_body($urandom_range(1, 5));
          end
          3: push_body($urandom_range(1, 7));
          4: push_body($urandom_range(0, 2));
          default: begin
            push_code($urandom_range(0, 999));
            push_body($urandom_range(0, 1));
          end
        endcase
        send_line();
      end
      // leave the reply open now and then
      if (kind != 9) begin
        push_code(code);
        if ($urandom_range(0, 2) != 0) begin
          line_buf.insert(line_buf.size(), CharSpace);
          push_body($urandom_range(0, 5));
        end
        send_line();
      end
    end else begin
      lines = $urandom_range(0, 8);
      for (int i = 0; i < lines; i++)
        line_buf.insert(line_buf.size(), ByteW'($urandom_range(0, 255)));
      send_line();
    end
  endtask

  // Main sequence
  initial begin
    int start;
    sb         = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_byte    = '0;
    wr_en      = 1'b0;
    wr_index   = RegDelimFirst;
    wr_data    = '0;
    hold_req   = 0;
    no_gaps    = 0;
    burst_left = 0;
    sent_count = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Open a multi-line reply whose body holds a lone CR and a NUL
    send_str("123-");
    send_byte(CharCr);
    send_byte(8'h00);
    send_delim();
    // Drop a short line, echo a non-numeric line, close without separator
    send_str("2-");
    send_delim();
    send_byte(8'hff);
    send_str("bc");
    send_delim();
    send_str("123");
    send_delim();
    // Leave a CR pending across a switch to a one-byte dash delimiter
    send_str("000");
    send_byte(CharCr);
    wait_idle();
    set_config(CharDash, CharLf, DelimLengthOne);
    send_byte(CharDash);
    wait_idle();

    // Random replies under several delimiter settings
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: set_config(CharCr, CharLf, DelimLengthReset);
        1: set_config(CharLf, 8'h00, DelimLengthOne);
        2: set_config(8'h00, 8'hff, DelimLengthReset);
        3: set_config(8'hff, 8'h00, DelimLengthOne);
        4: set_config(CharCr, CharCr, 2'd3);
        default: set_config(ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)),
                            2'd0);
      endcase
      // first phase: receiver holds off while bytes keep coming
      no_gaps  = (p == 0);
      hold_req = (p == 0);
      start = sent_count;
      while (sent_count - start < PhaseBytes) send_reply();
      wait_idle();
    end

    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/ftprp_pkg.sv
design/ftprp_front.sv
design/ftprp_queue.sv
design/ftprp_back.sv
design/ftp_reply_line_parser_top.sv
design/ftprp_checker.sv
tb/ftp_reply_line_parser_top_tb.sv
